### hdl/ptl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_pkg
// Shared types, constants and character helpers for the policy token lexer.
// ----------------------------------------------------------------------------
package ptl_pkg;

  localparam int LINE_WIDTH   = 24;
  localparam int COLUMN_WIDTH = 16;
  localparam int LEN_WIDTH    = 16;
  localparam int TAB_STOP     = 8;

  localparam logic [LINE_WIDTH-1:0]   LINE_MAX = {LINE_WIDTH{1'b1}};
  localparam logic [COLUMN_WIDTH-1:0] COL_MAX  = {COLUMN_WIDTH{1'b1}};
  localparam logic [LEN_WIDTH-1:0]    LEN_MAX  = {LEN_WIDTH{1'b1}};

  // Record types
  localparam logic [1:0] REC_TEXT  = 2'd0;
  localparam logic [1:0] REC_TOKEN = 2'd1;
  localparam logic [1:0] REC_ERROR = 2'd2;

  // Token kinds
  localparam logic [4:0] KIND_LBRACE = 5'd0;
  localparam logic [4:0] KIND_ARROW  = 5'd9;
  localparam logic [4:0] KIND_STRING = 5'd10;
  localparam logic [4:0] KIND_KW0    = 5'd11;
  localparam logic [4:0] KIND_IDENT  = 5'd18;
  localparam logic [4:0] KIND_END    = 5'd19;

  // Error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_DASH  = 2'd1;
  localparam logic [1:0] ERR_NL    = 2'd2;
  localparam logic [1:0] ERR_UNEXP = 2'd3;

  localparam int NUM_KW = 7;

  typedef struct packed {
    logic [1:0]              rtype;
    logic [4:0]              kind;
    logic [7:0]              tbyte;
    logic [LINE_WIDTH-1:0]   line;
    logic [COLUMN_WIDTH-1:0] col;
    logic [LEN_WIDTH-1:0]    len;
    logic [1:0]              err;
    logic                    last;
  } rec_t;

  // Keyword lengths
  function automatic logic [3:0] kw_len(input logic [2:0] k);
    case (k)
      3'd0:    kw_len = 4'd5;
      3'd1:    kw_len = 4'd6;
      3'd2:    kw_len = 4'd4;
      3'd3:    kw_len = 4'd8;
      3'd4:    kw_len = 4'd2;
      3'd5:    kw_len = 4'd4;
      default: kw_len = 4'd4;
    endcase
  endfunction

  // Keyword characters: basic linear expr topology pg type file
  function automatic logic [7:0] kw_byte(input logic [2:0] k, input logic [2:0] i);
    logic [63:0] s;
    case (k)
      3'd0:    s = {"basic", 24'h0};
      3'd1:    s = {"linear", 16'h0};
      3'd2:    s = {"expr", 32'h0};
      3'd3:    s = "topology";
      3'd4:    s = {"pg", 48'h0};
      3'd5:    s = {"type", 32'h0};
      default: s = {"file", 32'h0};
    endcase
    kw_byte = s[63 - 8*i -: 8];
  endfunction

  function automatic logic is_ident_byte(input logic [7:0] b);
    is_ident_byte = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
                    (b >= "0" && b <= "9") || b == "_" || b == ".";
  endfunction

  // Single-character tokens; returns {hit, kind}
  function automatic logic [5:0] single_kind(input logic [7:0] b);
    case (b)
      "{":     single_kind = {1'b1, 5'd0};
      "}":     single_kind = {1'b1, 5'd1};
      "(":     single_kind = {1'b1, 5'd2};
      ")":     single_kind = {1'b1, 5'd3};
      ":":     single_kind = {1'b1, 5'd4};
      ",":     single_kind = {1'b1, 5'd5};
      "+":     single_kind = {1'b1, 5'd6};
      "*":     single_kind = {1'b1, 5'd7};
      "=":     single_kind = {1'b1, 5'd8};
      default: single_kind = 6'd0;
    endcase
  endfunction

endpackage

### hdl/ptl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_front
// Scanner front end: takes one byte item per cycle while take_i is high,
// updates position and mode, and produces zero to two records for the queue.
// ----------------------------------------------------------------------------
module ptl_front import ptl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] byte_i,
  input  logic       end_i,
  output logic [1:0] push_cnt_o,
  output rec_t       rec0_o,
  output rec_t       rec1_o
);

  typedef enum logic [2:0] {
    M_NORMAL, M_COMMENT, M_DASH, M_STRING, M_IDENT, M_HALT
  } mode_e;

  mode_e                   mode_q, mode_d;
  logic [LINE_WIDTH-1:0]   line_q, line_d;
  logic [COLUMN_WIDTH-1:0] col_q, col_d, tsc_q, tsc_d;
  logic [LEN_WIDTH-1:0]    len_q, len_d;
  logic [NUM_KW-1:0]       mask_q, mask_d;
  rec_t                    recs [2];
  logic [1:0]              n;

  function automatic rec_t mk(input logic [1:0] t, input logic [4:0] k,
                              input logic [7:0] b, input logic [LINE_WIDTH-1:0] l,
                              input logic [COLUMN_WIDTH-1:0] c,
                              input logic [LEN_WIDTH-1:0] len, input logic [1:0] e);
    rec_t r;
    r.rtype = t; r.kind = k; r.tbyte = b; r.line = l;
    r.col = c; r.len = len; r.err = e; r.last = 1'b0;
    mk = r;
  endfunction

  function automatic logic [COLUMN_WIDTH-1:0] col_inc(input logic [COLUMN_WIDTH-1:0] c);
    col_inc = (c == COL_MAX) ? COL_MAX : c + 1'b1;
  endfunction

  // Next-state and record generation
  always_comb begin
    logic                  scan;
    logic [5:0]            sk;
    logic [4:0]            kind;
    logic [COLUMN_WIDTH:0] tab_sum;
    mode_d = mode_q; line_d = line_q; col_d = col_q; tsc_d = tsc_q;
    len_d = len_q; mask_d = mask_q;
    recs[0] = '0; recs[1] = '0; n = 2'd0;
    scan = 1'b0; sk = '0; kind = KIND_IDENT; tab_sum = '0;
    if (take_i && mode_q != M_HALT) begin
      if (end_i) begin
        unique case (mode_q)
          M_COMMENT: begin
            line_d = (line_d == LINE_MAX) ? LINE_MAX : line_d + 1'b1;
            col_d  = '0;
          end
          M_DASH: begin
            col_d = col_inc(col_d);
          end
          M_STRING: begin
            col_d = col_inc(col_d);
            recs[0] = mk(REC_TOKEN, KIND_STRING, 8'd0, line_d, tsc_d, len_d, ERR_NONE);
            n = 2'd1;
          end
          M_IDENT: begin
            for (int k = 0; k < NUM_KW; k++)
              if (mask_d[k] && len_d == LEN_WIDTH'(kw_len(3'(k))))
                kind = KIND_KW0 + 5'(k);
            recs[0] = mk(REC_TOKEN, kind, 8'd0, line_d, tsc_d, len_d, ERR_NONE);
            n = 2'd1;
          end
          default: ;
        endcase
        if (mode_q == M_DASH) begin
          recs[0] = mk(REC_ERROR, KIND_LBRACE, 8'd0, line_d, col_d, '0, ERR_DASH);
          n = 2'd1;
          mode_d = M_HALT;
        end else begin
          recs[n[0]] = mk(REC_TOKEN, KIND_END, 8'd0, line_d, col_d, '0, ERR_NONE);
          n = n + 2'd1;
          mode_d = M_NORMAL; line_d = LINE_WIDTH'(1); col_d = '0; tsc_d = '0;
          len_d = '0; mask_d = '1;
        end
      end else begin
        unique case (mode_q)
          M_COMMENT: begin
            if (byte_i == 8'h0a) begin
              line_d = (line_d == LINE_MAX) ? LINE_MAX : line_d + 1'b1;
              col_d  = '0;
              mode_d = M_NORMAL;
            end
          end
          M_DASH: begin
            col_d = col_inc(col_d);
            if (byte_i == ">") begin
              recs[0] = mk(REC_TOKEN, KIND_ARROW, 8'd0, line_d, tsc_d, '0, ERR_NONE);
              mode_d = M_NORMAL;
            end else begin
              recs[0] = mk(REC_ERROR, KIND_LBRACE, byte_i, line_d, col_d, '0, ERR_DASH);
              mode_d = M_HALT;
            end
            n = 2'd1;
          end
          M_STRING: begin
            if (byte_i == "\"") begin
              col_d = col_inc(col_d);
              recs[0] = mk(REC_TOKEN, KIND_STRING, 8'd0, line_d, tsc_d, len_d, ERR_NONE);
              mode_d = M_NORMAL;
            end else if (byte_i == 8'h0a) begin
              recs[0] = mk(REC_ERROR, KIND_LBRACE, byte_i, line_d, col_d, '0, ERR_NL);
              mode_d = M_HALT;
            end else begin
              col_d = col_inc(col_d);
              len_d = (len_d == LEN_MAX) ? LEN_MAX : len_d + 1'b1;
              recs[0] = mk(REC_TEXT, KIND_STRING, byte_i, line_d, col_d, len_d, ERR_NONE);
            end
            n = 2'd1;
          end
          M_IDENT: begin
            if (is_ident_byte(byte_i)) begin
              col_d = col_inc(col_d);
              for (int k = 0; k < NUM_KW; k++)
                if (len_d >= LEN_WIDTH'(kw_len(3'(k))) ||
                    kw_byte(3'(k), len_d[2:0]) != byte_i)
                  mask_d[k] = 1'b0;
              len_d = (len_d == LEN_MAX) ? LEN_MAX : len_d + 1'b1;
              recs[0] = mk(REC_TEXT, KIND_IDENT, byte_i, line_d, col_d, len_d, ERR_NONE);
              n = 2'd1;
            end else begin
              for (int k = 0; k < NUM_KW; k++)
                if (mask_d[k] && len_d == LEN_WIDTH'(kw_len(3'(k))))
                  kind = KIND_KW0 + 5'(k);
              recs[0] = mk(REC_TOKEN, kind, 8'd0, line_d, tsc_d, len_d, ERR_NONE);
              n = 2'd1;
              mode_d = M_NORMAL;
              scan = 1'b1;
            end
          end
          default: begin
            mode_d = M_NORMAL;
            scan = 1'b1;
          end
        endcase
        // Normal-mode scan of one byte
        if (scan) begin
          col_d = col_inc(col_d);
          sk = single_kind(byte_i);
          if (byte_i == " " || byte_i == 8'h0d) begin
          end else if (byte_i == 8'h09) begin
            tab_sum = {1'b0, col_d} + (COLUMN_WIDTH+1)'(TAB_STOP) -
                      (COLUMN_WIDTH+1)'(col_d & COLUMN_WIDTH'(TAB_STOP-1));
            col_d = tab_sum[COLUMN_WIDTH] ? COL_MAX : tab_sum[COLUMN_WIDTH-1:0];
          end else if (byte_i == 8'h0a) begin
            line_d = (line_d == LINE_MAX) ? LINE_MAX : line_d + 1'b1;
            col_d  = '0;
          end else if (byte_i == "#") begin
            mode_d = M_COMMENT;
          end else if (sk[5]) begin
            recs[n[0]] = mk(REC_TOKEN, sk[4:0], 8'd0, line_d, col_d, '0, ERR_NONE);
            n = n + 2'd1;
          end else if (byte_i == "-") begin
            tsc_d  = col_d;
            mode_d = M_DASH;
          end else begin
            tsc_d = col_d; len_d = '0; mask_d = '1;
            if (byte_i == "\"") begin
              mode_d = M_STRING;
            end else if (is_ident_byte(byte_i)) begin
              mode_d = M_IDENT;
              for (int k = 0; k < NUM_KW; k++)
                if (kw_byte(3'(k), 3'd0) != byte_i) mask_d[k] = 1'b0;
              len_d = LEN_WIDTH'(1);
              recs[n[0]] = mk(REC_TEXT, KIND_IDENT, byte_i, line_d, col_d, len_d,
                              ERR_NONE);
              n = n + 2'd1;
            end else begin
              recs[n[0]] = mk(REC_ERROR, KIND_LBRACE, byte_i, line_d, col_d, '0,
                              ERR_UNEXP);
              n = n + 2'd1;
              mode_d = M_HALT;
            end
          end
        end
      end
      if (n == 2'd2) recs[1].last = 1'b1;
      else if (n == 2'd1) recs[0].last = 1'b1;
    end
  end

  assign push_cnt_o = n;
  assign rec0_o     = recs[0];
  assign rec1_o     = recs[1];

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_NORMAL;
      line_q <= LINE_WIDTH'(1);
      col_q  <= '0;
      tsc_q  <= '0;
      len_q  <= '0;
      mask_q <= '1;
    end else begin
      mode_q <= mode_d;
      line_q <= line_d;
      col_q  <= col_d;
      tsc_q  <= tsc_d;
      len_q  <= len_d;
      mask_q <= mask_d;
    end
  end

endmodule

### hdl/ptl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_queue
// Four-entry record queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module ptl_queue import ptl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  rec_t       rec0_i,
  input  rec_t       rec1_i,
  input  logic       pop_i,
  output logic       room_o,
  output logic       head_valid_o,
  output rec_t       head_o
);

  rec_t       mem_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q, cnt_d;

  assign room_o       = cnt_q <= 3'd2;
  assign head_valid_o = cnt_q != 3'd0;
  assign head_o       = mem_q[rd_q];
  assign cnt_d        = cnt_q + 3'(push_cnt_i) - 3'(pop_i);

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_q] <= rec0_i;
    if (push_cnt_i == 2'd2) mem_q[wr_q + 2'd1] <= rec1_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_cnt_i;
      rd_q  <= rd_q + 2'(pop_i);
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt_i != 2'd0 |-> room_o)
    else $error("queue push without room");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("queue pop while empty");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q == $past(cnt_q) + 3'($past(push_cnt_i)) - 3'($past(pop_i)))
    else $error("queue count mismatch");

endmodule

### hdl/ptl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_back
// Output stage: pulls one record per cycle from the queue into the port
// register while it is empty or being taken, and holds it until taken.
// ----------------------------------------------------------------------------
module ptl_back import ptl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic head_valid_i,
  input  rec_t head_i,
  output logic pop_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  output rec_t out_o
);

  logic valid_q;
  rec_t rec_q;

  assign pop_o       = head_valid_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_o       = rec_q;

  // Payload register
  always_ff @(posedge clk_i) begin
    if (pop_o) rec_q <= head_i;
  end

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

### hdl/policy_token_lexer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// policy_token_lexer_core
// Byte-serial lexer for a small policy language.
// ----------------------------------------------------------------------------
// Path: a record is written into the queue at the edge that accepts its
//   item, then loaded into the output register once that is free or being taken.
// Throughput: one item per cycle while the four-entry queue has room for two
//   records; output drains one record per cycle while out_ready_i is high.
// Reset: asynchronous, active low; line 1, column 0, normal mode, queue empty.
module policy_token_lexer_core import ptl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              byte_in_i,
  input  logic                    end_of_input_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              record_type_o,
  output logic [4:0]              token_kind_o,
  output logic [7:0]              text_byte_o,
  output logic [LINE_WIDTH-1:0]   line_number_o,
  output logic [COLUMN_WIDTH-1:0] column_number_o,
  output logic [LEN_WIDTH-1:0]    token_length_o,
  output logic [1:0]              error_code_o,
  output logic                    last_result_o
);

  logic [1:0] push_cnt;
  rec_t       rec0, rec1, head, out_rec;
  logic       room, head_valid, pop;

  assign in_ready_o = room;

  ptl_front u_front (
    .clk_i, .rst_ni,
    .take_i     (in_valid_i && room),
    .byte_i     (byte_in_i),
    .end_i      (end_of_input_i),
    .push_cnt_o (push_cnt),
    .rec0_o     (rec0),
    .rec1_o     (rec1)
  );

  ptl_queue u_queue (
    .clk_i, .rst_ni,
    .push_cnt_i   (push_cnt),
    .rec0_i       (rec0),
    .rec1_i       (rec1),
    .pop_i        (pop),
    .room_o       (room),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  ptl_back u_back (
    .clk_i, .rst_ni,
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_o        (out_rec)
  );

  assign record_type_o   = out_rec.rtype;
  assign token_kind_o    = out_rec.kind;
  assign text_byte_o     = out_rec.tbyte;
  assign line_number_o   = out_rec.line;
  assign column_number_o = out_rec.col;
  assign token_length_o  = out_rec.len;
  assign error_code_o    = out_rec.err;
  assign last_result_o   = out_rec.last;

endmodule
